// ===== rtl/cwc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwc_pkg
// shared types, codes and constants of the congestion window controller
// ----------------------------------------------------------------------------
package cwc_pkg;

   localparam int SEGMENT_SIZE_DEF = 1024;

   localparam int WIN_W   = 18;
   localparam int WORD_W  = 32;
   localparam int DUP_W   = 16;
   localparam int EV_W    = 3;
   localparam int PHASE_W = 2;
   localparam int REQ_DATA_W  = 128;
   localparam int RSP_DATA_W  = 160;

   localparam logic signed [WIN_W-1:0] THRESH_INIT = 18'sd65536;
   localparam logic signed [WIN_W-1:0] CLAMP_GAP   = 18'sd1024;
   localparam logic [DUP_W-1:0]        DUP_TRIGGER = 16'd3;

   localparam logic [EV_W-1:0] EV_NEW     = 3'd0;
   localparam logic [EV_W-1:0] EV_TIMEOUT = 3'd1;
   localparam logic [EV_W-1:0] EV_DUP     = 3'd2;
   localparam logic [EV_W-1:0] EV_THIRD   = 3'd3;
   localparam logic [EV_W-1:0] EV_THRESH  = 3'd4;

   localparam logic [PHASE_W-1:0] PH_SLOW  = 2'd0;
   localparam logic [PHASE_W-1:0] PH_RECOV = 2'd1;
   localparam logic [PHASE_W-1:0] PH_AVOID = 2'd2;

   localparam logic OP_ACK     = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIVIDE,
      ST_COMMIT
   } cwc_state_type;

   typedef struct packed {
      logic capture;
      logic start_div;
      logic commit;
   } cwc_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
      logic out_free;
   } cwc_stat_type;

endpackage
`default_nettype wire

// ===== rtl/congestion_window_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// congestion_window_controller
// reno style congestion window control, one result transaction per request
// ----------------------------------------------------------------------------
// a request is captured, classified in the exec state and committed into the
//   result register; a new ack in congestion avoidance first runs the divider
// a new request is taken only after the previous commit, which waits for a free
// result register; a waiting result does not block the next request
// reset: synchronous; slow start, window one segment, threshold 65536
// ----------------------------------------------------------------------------
module congestion_window_controller #(
   parameter int SEGMENT_SIZE = cwc_pkg::SEGMENT_SIZE_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // ack_seq, ack_len, ack_offset, ack_total
   input  wire logic [cwc_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation
   input  wire logic [0:0]                     req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // phase_now, window_now, threshold_now, dup_now, unexpected, retransmit,
   // resend_offset, resend_seq, flight_clear, acked_total, zero pad
   output logic [cwc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // event_kind
   output logic [cwc_pkg::EV_W-1:0]            rsp_tuser
);
   import cwc_pkg::*;

   cwc_cmd_type  cmd;
   cwc_stat_type stat;

   cwc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cwc_datapath #(
      .SEGMENT_SIZE (SEGMENT_SIZE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== rtl/cwc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwc_div
// restoring serial divider, segment size squared over the window, one bit a cycle
// ----------------------------------------------------------------------------
module cwc_div #(
   parameter int SEGMENT_SIZE = cwc_pkg::SEGMENT_SIZE_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [cwc_pkg::WIN_W-2:0]  divisor,
   output logic                            done,
   output logic [cwc_pkg::WIN_W-1:0]       quotient
);
   import cwc_pkg::*;

   localparam int DVW   = 2 * $clog2(SEGMENT_SIZE) + 1;
   localparam int CNT_W = $clog2(DVW + 1);
   localparam int DR_W  = WIN_W - 1;
   localparam logic [DVW-1:0] DIVIDEND = DVW'(SEGMENT_SIZE * SEGMENT_SIZE);

   logic [DR_W-1:0]  rem_ff, rem_in;
   logic [DVW-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DR_W:0]    rem_sh;
   logic [DR_W:0]    rem_sub;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DVW-1]};
      ge      = rem_sh >= {1'b0, divisor};
      rem_sub = rem_sh - {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = DIVIDEND;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[DR_W-1:0] : rem_sh[DR_W-1:0];
         quo_in = {quo_ff[DVW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;

   // only the low window bits matter, the sum wraps anyway
   generate
      if (DVW >= WIN_W) begin : g_wide
         assign quotient = quo_ff[WIN_W-1:0];
      end else begin : g_narrow
         assign quotient = WIN_W'(quo_ff);
      end
   endgenerate

endmodule
`default_nettype wire

// ===== rtl/cwc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwc_ctrl
// sequencer: capture, optional division, commit into the result register
// ----------------------------------------------------------------------------
module cwc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire cwc_pkg::cwc_stat_type stat,
   output cwc_pkg::cwc_cmd_type       cmd
);
   import cwc_pkg::*;

   cwc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      cmd.capture   = 1'b0;
      cmd.start_div = 1'b0;
      cmd.commit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // no transaction is taken while reset is held
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.need_div) begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DIVIDE: begin
            if (stat.div_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/cwc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cwc_datapath
// event classification, window and threshold update, result register
// ----------------------------------------------------------------------------
module cwc_datapath #(
   parameter int SEGMENT_SIZE = cwc_pkg::SEGMENT_SIZE_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire cwc_pkg::cwc_cmd_type             cmd,
   output cwc_pkg::cwc_stat_type                 stat,
   input  wire logic [cwc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [0:0]                       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [cwc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [cwc_pkg::EV_W-1:0]              rsp_tuser
);
   import cwc_pkg::*;

   localparam logic signed [WIN_W-1:0] MSS  = WIN_W'(SEGMENT_SIZE);
   localparam logic signed [WIN_W-1:0] MSS3 = WIN_W'(3 * SEGMENT_SIZE);

   // captured transaction
   logic              op_ff;
   logic [WORD_W-1:0] seq_ff, len_ff, off_ff, tot_ff;

   // architectural state
   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic signed [WIN_W-1:0] window_ff, window_in;
   logic signed [WIN_W-1:0] thr_ff, thr_in;
   logic [DUP_W-1:0]        dup_ff, dup_in;
   logic [WORD_W-1:0]       pseq_ff, pseq_in, plen_ff, plen_in;
   logic [WORD_W-1:0]       poff_ff, poff_in, ptot_ff, ptot_in;
   logic                    invalid_ff, invalid_in;

   // result register
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [EV_W-1:0]         rsp_ev_ff;

   logic [EV_W-1:0]         ev;
   logic                    retx, flight;
   logic                    out_free;
   logic                    div_done;
   logic [WIN_W-1:0]        quotient;
   logic [WIN_W-2:0]        divisor;
   logic signed [WIN_W-1:0] inc, grow_sum, grown, half;
   logic [WORD_W-1:0]       rseq, roff;

   assign divisor = (window_ff > 0) ? window_ff[WIN_W-2:0] : (WIN_W-1)'(1);

   cwc_div #(
      .SEGMENT_SIZE (SEGMENT_SIZE)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   assign out_free      = !rsp_valid_ff || rsp_tready;
   assign stat.out_free = out_free;
   assign stat.div_done = div_done;
   assign stat.need_div = (ev == EV_NEW) && (phase_ff != PH_SLOW) && (phase_ff != PH_RECOV);

   always_comb begin
      inc      = (phase_ff == PH_SLOW || phase_ff == PH_RECOV) ? MSS : $signed(quotient);
      grow_sum = window_ff + inc;
      grown    = (grow_sum >= thr_ff) ? thr_ff - CLAMP_GAP : grow_sum;
      half     = (window_ff + $signed({{(WIN_W-1){1'b0}}, window_ff[WIN_W-1]})) >>> 1;
   end

   always_comb begin
      phase_in   = phase_ff;
      window_in  = window_ff;
      thr_in     = thr_ff;
      dup_in     = dup_ff;
      invalid_in = invalid_ff;
      pseq_in    = pseq_ff;
      plen_in    = plen_ff;
      poff_in    = poff_ff;
      ptot_in    = ptot_ff;
      retx       = 1'b0;
      flight     = 1'b0;

      if (op_ff == OP_TIMEOUT) begin
         ev = EV_TIMEOUT;
      end else if (window_ff >= thr_ff) begin
         ev = EV_THRESH;
      end else if (dup_ff == DUP_TRIGGER) begin
         ev   = EV_THIRD;
         retx = 1'b1;
      end else if (seq_ff == pseq_ff && len_ff == plen_ff &&
                   off_ff == poff_ff && tot_ff == ptot_ff) begin
         ev = EV_DUP;
      end else begin
         ev      = EV_NEW;
         pseq_in = seq_ff;
         plen_in = len_ff;
         poff_in = off_ff;
         ptot_in = tot_ff;
      end

      case (ev)
         EV_NEW: begin
            if (phase_ff == PH_SLOW) begin
               window_in = grown;
            end else if (phase_ff == PH_RECOV) begin
               window_in = thr_ff;
               phase_in  = PH_AVOID;
            end else begin
               window_in = grown;
               phase_in  = PH_AVOID;
            end
            dup_in = '0;
            flight = 1'b1;
         end
         EV_TIMEOUT: begin
            thr_in    = half;
            window_in = MSS;
            dup_in    = '0;
            retx      = 1'b1;
            flight    = 1'b1;
            phase_in  = PH_SLOW;
         end
         EV_DUP: begin
            if (phase_ff == PH_RECOV) begin
               window_in = grown;
               flight    = 1'b1;
            end else begin
               dup_in = dup_ff + 1'b1;
               retx   = 1'b1;
            end
         end
         EV_THIRD: begin
            if (phase_ff == PH_RECOV) begin
               invalid_in = 1'b1;
            end else begin
               thr_in    = half;
               window_in = half + MSS3;
               flight    = 1'b1;
               phase_in  = PH_RECOV;
            end
         end
         default: begin
            if (phase_ff == PH_SLOW) begin
               window_in = MSS;
               thr_in    = THRESH_INIT;
               dup_in    = '0;
               flight    = 1'b1;
               phase_in  = PH_AVOID;
            end else begin
               invalid_in = 1'b1;
            end
         end
      endcase

      roff = retx ? poff_in : '0;
      rseq = retx ? pseq_in + 1'b1 : '0;
      rsp_data_in = {7'd0, ptot_in, flight, rseq, roff, retx, invalid_in,
                     dup_in, thr_in, window_in, phase_in};
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_tuser[0];
         seq_ff <= req_tdata[31:0];
         len_ff <= req_tdata[63:32];
         off_ff <= req_tdata[95:64];
         tot_ff <= req_tdata[127:96];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SLOW;
         window_ff  <= MSS;
         thr_ff     <= THRESH_INIT;
         dup_ff     <= '0;
         pseq_ff    <= '0;
         plen_ff    <= '0;
         poff_ff    <= '0;
         ptot_ff    <= '0;
         invalid_ff <= 1'b0;
      end else if (cmd.commit) begin
         phase_ff   <= phase_in;
         window_ff  <= window_in;
         thr_ff     <= thr_in;
         dup_ff     <= dup_in;
         pseq_ff    <= pseq_in;
         plen_ff    <= plen_in;
         poff_ff    <= poff_in;
         ptot_ff    <= ptot_in;
         invalid_ff <= invalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_ev_ff   <= ev;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ev_ff;

   a_commit_free : assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> out_free)
      else $error("commit while result register is occupied");

   a_sticky : assert property (@(posedge clock) disable iff (reset)
      invalid_ff |=> invalid_ff)
      else $error("unexpected flag cleared");

   a_new_no_retx : assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !(rsp_tdata[55] && rsp_tuser == EV_NEW))
      else $error("retransmit reported on a new ack");

   a_div_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.start_div |-> !div_done && !cmd.commit)
      else $error("divider started at a wrong time");

endmodule
`default_nettype wire
